[src/ole_pkg.sv]
`timescale 1ns / 1ps
// ole_pkg: shared types, codes and ring addressing for the ordered list engine
// no dependencies

package ole_pkg;

   localparam int DEPTH       = 16;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CNT_W       = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ADDR_W:0]  DEPTH_V = (ADDR_W + 1)'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [2:0] CMD_REMOVE     = 3'd2;
   localparam logic [2:0] CMD_DUMP       = 3'd3;
   localparam logic [2:0] CMD_INSERT     = 3'd4;
   localparam logic [2:0] CMD_REVERSE    = 3'd5;
   localparam logic [2:0] CMD_CLEAR      = 3'd6;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BADPOS = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   typedef enum logic [2:0] {
      OP_PUSH_BACK,
      OP_PUSH_FRONT,
      OP_REMOVE,
      OP_DUMP,
      OP_INSERT,
      OP_REVERSE,
      OP_CLEAR,
      OP_NOP
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DUMP,
      S_DRAIN,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PLACE
   } state_type;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] value;
      logic [4:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] item_value;
      logic               has_value;
      logic               last;
      logic [1:0]         status;
      logic [4:0]         length;
   } rsp_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] value;
      logic [4:0]         position;
   } job_type;

   // physical slot at a logical offset from head, walking forward or backward
   function automatic logic [ADDR_W-1:0] ring_step(logic [ADDR_W-1:0] head, logic rev,
                                                   logic [ADDR_W:0] off);
      logic [ADDR_W:0] h;
      logic [ADDR_W:0] s;
      h = {1'b0, head};
      if (!rev) begin
         s = h + off;
         if (s >= DEPTH_V) s = s - DEPTH_V;
      end else begin
         if (h >= off) s = h - off;
         else s = h + DEPTH_V - off;
      end
      return s[ADDR_W-1:0];
   endfunction

endpackage

[src/ole_front.sv]
`timescale 1ns / 1ps
// ole_front: takes commands, decodes them and queues them for the back end
// depends on ole_pkg

module ole_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ole_pkg::req_type req_data,
   output logic             job_valid,
   input  logic             job_ready,
   output ole_pkg::job_type job
);
   import ole_pkg::*;

   job_type            q_ff [QUEUE_DEPTH];
   logic [QADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  fill_ff, fill_in;
   logic               push, pop;
   job_type            decoded;

   always_comb begin
      decoded.value    = req_data.value;
      decoded.position = req_data.position;
      unique case (req_data.command)
         CMD_PUSH_BACK:  decoded.op = OP_PUSH_BACK;
         CMD_PUSH_FRONT: decoded.op = OP_PUSH_FRONT;
         CMD_REMOVE:     decoded.op = OP_REMOVE;
         CMD_DUMP:       decoded.op = OP_DUMP;
         CMD_INSERT:     decoded.op = OP_INSERT;
         CMD_REVERSE:    decoded.op = OP_REVERSE;
         CMD_CLEAR:      decoded.op = OP_CLEAR;
         default:        decoded.op = OP_NOP;
      endcase
   end

   assign busy      = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = start && !busy;
   assign job_valid = (fill_ff != '0);
   assign pop       = job_valid && job_ready;
   assign job       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         if (wr_ptr_ff == QADDR_W'(QUEUE_DEPTH - 1)) wr_ptr_in = '0;
         else wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         if (rd_ptr_ff == QADDR_W'(QUEUE_DEPTH - 1)) rd_ptr_in = '0;
         else rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) fill_in = fill_ff + 1'b1;
      else if (pop && !push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= decoded;
   end

endmodule

[src/ole_back.sv]
`timescale 1ns / 1ps
// ole_back: carries out queued commands on a ring-addressed entry memory
// depends on ole_pkg

module ole_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  ole_pkg::job_type job,
   output logic             rsp_valid,
   output ole_pkg::rsp_type rsp_data
);
   import ole_pkg::*;

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rdata_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
   logic signed [31:0] mem_wdata;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  head_ff, head_in;
   logic               rev_ff, rev_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   job_type            job_ff, job_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               pend_last_ff, pend_last_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         status;
   logic [CNT_W-1:0]   idx_dec;

   assign idx_dec = idx_ff - 1'b1;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      rev_in        = rev_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      job_in        = job_ff;
      job_ready     = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = head_ff;
      mem_wdata     = job.value;
      mem_raddr     = ring_step(head_ff, rev_ff, (ADDR_W + 1)'(idx_ff));
      pend_valid_in = 1'b0;
      pend_last_in  = 1'b0;
      status        = ST_OK;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;

      // entry read in the previous cycle goes out now
      if (pend_valid_ff) begin
         rsp_valid_in       = 1'b1;
         rsp_in.item_value  = rdata_ff;
         rsp_in.has_value   = 1'b1;
         rsp_in.last        = pend_last_ff;
         rsp_in.status      = ST_OK;
         rsp_in.length      = count_ff;
      end

      unique case (state_ff)
         S_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               rsp_valid_in = 1'b1;
               case (job.op)
                  OP_PUSH_BACK: begin
                     if (count_ff == DEPTH_C) begin
                        status = ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = ring_step(head_ff, rev_ff, (ADDR_W + 1)'(count_ff));
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  OP_PUSH_FRONT: begin
                     if (count_ff == DEPTH_C) begin
                        status = ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = ring_step(head_ff, !rev_ff, (ADDR_W + 1)'(1));
                        head_in   = mem_waddr;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (count_ff != '0) begin
                        head_in  = ring_step(head_ff, rev_ff, (ADDR_W + 1)'(1));
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_DUMP: begin
                     if (count_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        idx_in       = '0;
                        state_in     = S_DUMP;
                     end
                  end
                  OP_INSERT: begin
                     if (job.position > count_ff) begin
                        status = ST_BADPOS;
                     end else if (count_ff == DEPTH_C) begin
                        status = ST_FULL;
                     end else if (job.position == count_ff) begin
                        mem_we    = 1'b1;
                        mem_waddr = ring_step(head_ff, rev_ff, (ADDR_W + 1)'(count_ff));
                        count_in  = count_ff + 1'b1;
                     end else begin
                        rsp_valid_in = 1'b0;
                        job_in       = job;
                        idx_in       = count_ff;
                        state_in     = S_SHIFT_RD;
                     end
                  end
                  OP_REVERSE: begin
                     if (count_ff > CNT_W'(1)) begin
                        head_in = ring_step(head_ff, rev_ff, (ADDR_W + 1)'(count_ff - 1'b1));
                        rev_in  = !rev_ff;
                     end
                  end
                  OP_CLEAR: count_in = '0;
                  default: ;
               endcase
               rsp_in.item_value = '0;
               rsp_in.has_value  = 1'b0;
               rsp_in.last       = 1'b1;
               rsp_in.status     = status;
               rsp_in.length     = count_in;
            end
         end
         S_DUMP: begin
            pend_valid_in = 1'b1;
            pend_last_in  = (idx_ff + 1'b1 == count_ff);
            idx_in        = idx_ff + 1'b1;
            if (pend_last_in) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            idx_in   = '0;
            state_in = S_IDLE;
         end
         S_SHIFT_RD: begin
            mem_raddr = ring_step(head_ff, rev_ff, (ADDR_W + 1)'(idx_dec));
            state_in  = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = ring_step(head_ff, rev_ff, (ADDR_W + 1)'(idx_ff));
            mem_wdata = rdata_ff;
            idx_in    = idx_dec;
            if (idx_dec == job_ff.position) state_in = S_PLACE;
            else state_in = S_SHIFT_RD;
         end
         S_PLACE: begin
            mem_we            = 1'b1;
            mem_waddr         = ring_step(head_ff, rev_ff, (ADDR_W + 1)'(job_ff.position));
            mem_wdata         = job_ff.value;
            count_in          = count_ff + 1'b1;
            idx_in            = '0;
            rsp_valid_in      = 1'b1;
            rsp_in.item_value = '0;
            rsp_in.has_value  = 1'b0;
            rsp_in.last       = 1'b1;
            rsp_in.status     = ST_OK;
            rsp_in.length     = count_in;
            state_in          = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         rev_ff        <= 1'b0;
         count_ff      <= '0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         pend_last_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         rev_ff        <= rev_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         pend_last_ff  <= pend_last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rdata_ff <= mem[mem_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[src/ordered_list_engine.sv]
`timescale 1ns / 1ps
// ordered_list_engine: top level of the bounded ordered list
// depends on ole_pkg, ole_front, ole_back
//
// usage:
//   a command transaction is taken at a clock edge with start high and busy low;
//   req_data carries command, value and position. busy is high while the
//   two-entry command queue is full.
//   results leave on rsp_data, each one for a single cycle with rsp_valid high;
//   the receiver cannot hold them off, so it must take every one.
// command handling:
//   with an idle back end, a status result is registered in the back end once
//   its command leaves the queue. a dump enters the dump state, reads one entry
//   per cycle through the read and result registers, and ends in a drain state.
//   an insert in the middle moves each entry up with a read state and a write
//   state, then places the value. all other commands finish in the idle state:
//   remove and reverse only move the ring head, pushes write one entry.
// reset:
//   synchronous reset empties the list and the queue; entry data is kept.

module ordered_list_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ole_pkg::req_type req_data,
   output logic             rsp_valid,
   output ole_pkg::rsp_type rsp_data
);
   import ole_pkg::*;

   logic    job_valid;
   logic    job_ready;
   job_type job;

   ole_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job)
   );

   ole_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
